// ----- hdl/tsc_pkg.sv -----
// shared constants and types of the triangle shape classifier
package tsc_pkg;

  localparam int unsigned FIELD_W = 32;   // width of a coordinate field on the port
  localparam int unsigned LIMB_W  = 32;   // limb width of the pipelined multipliers

  // cos^2(145 deg) as unsigned Q0.32
  localparam logic [LIMB_W-1:0] COS2_Q32 = 32'd2881966313;
  // the dot product is carried doubled, so 2^32 / 4 remains on the left side
  localparam int unsigned COS2_SHIFT = 30;

  localparam int unsigned NEEDLE_RATIO   = 100;
  localparam int unsigned NEEDLE_EXTRA_W = 7;   // bits that the ratio adds

  localparam logic [1:0] CLASS_OK     = 2'd0;
  localparam logic [1:0] CLASS_NEEDLE = 2'd1;
  localparam logic [1:0] CLASS_OBTUSE = 2'd2;

  localparam logic [1:0] EDGE_P1P2 = 2'd0;
  localparam logic [1:0] EDGE_P0P2 = 2'd1;
  localparam logic [1:0] EDGE_P0P1 = 2'd2;

  typedef struct packed {
    logic [1:0] shape_class;
    logic [1:0] edge_index;
  } tsc_result_t;

endpackage

// ----- hdl/tsc_if.sv -----
// channel interfaces: triangle input and class result
interface tsc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tsc_pkg::FIELD_W-1:0]    x0, y0, z0;
  logic signed [tsc_pkg::FIELD_W-1:0]    x1, y1, z1;
  logic signed [tsc_pkg::FIELD_W-1:0]    x2, y2, z2;

  modport source (output valid, x0, y0, z0, x1, y1, z1, x2, y2, z2, input ready);
  modport sink   (input valid, x0, y0, z0, x1, y1, z1, x2, y2, z2, output ready);
endinterface

interface tsc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] shape_class;
  logic [1:0] edge_index;

  modport source (output valid, shape_class, edge_index, input ready);
  modport sink   (input valid, shape_class, edge_index, output ready);
endinterface

// ----- hdl/tsc_mul.sv -----
// pipelined unsigned multiplier built from limb products and a row accumulator chain
module tsc_mul #(
  parameter int unsigned A_W = 32,
  parameter int unsigned B_W = 32
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  localparam int unsigned LW  = tsc_pkg::LIMB_W;
  localparam int unsigned NA  = (A_W + LW - 1) / LW;
  localparam int unsigned NB  = (B_W + LW - 1) / LW;
  localparam int unsigned RW  = LW * (NB + 1);
  localparam int unsigned ACW = LW * (NA + NB);

  logic [LW*NA-1:0] a_ext;
  logic [LW*NB-1:0] b_ext;
  logic [2*LW-1:0]  pp_r    [NA][NB];
  logic [RW-1:0]    row_nxt [NA];
  logic [RW-1:0]    row_r   [NA][NA];  // [stage][row]
  logic [ACW-1:0]   acc_r   [NA];

  assign a_ext = (LW*NA)'(a);
  assign b_ext = (LW*NB)'(b);

  // even and odd limb products of a row do not overlap, so each half is a plain concatenation
  always_comb begin
    logic [RW-1:0] ev;
    logic [RW-1:0] od;
    for (int i = 0; i < NA; i++) begin
      ev = '0;
      od = '0;
      for (int j = 0; j < NB; j += 2) ev[j*LW +: 2*LW] = pp_r[i][j];
      for (int j = 1; j < NB; j += 2) od[j*LW +: 2*LW] = pp_r[i][j];
      row_nxt[i] = ev + od;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= (2*LW)'(a_ext[i*LW +: LW]) * (2*LW)'(b_ext[j*LW +: LW]);
        end
      end
      for (int i = 0; i < NA; i++) row_r[0][i] <= row_nxt[i];
      for (int s = 1; s < NA; s++) begin
        for (int i = 0; i < NA; i++) row_r[s][i] <= row_r[s-1][i];
      end
      acc_r[0] <= ACW'(row_nxt[0]);
      for (int s = 1; s < NA; s++) begin
        acc_r[s] <= acc_r[s-1] + (ACW'(row_r[s-1][s]) << (LW * s));
      end
    end
  end

  assign p = acc_r[NA-1][A_W+B_W-1:0];

endmodule

// ----- hdl/tsc_edge.sv -----
// edge vectors and squared edge lengths of one triangle
module tsc_edge #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [tsc_pkg::FIELD_W-1:0] x0, y0, z0,
  input  logic signed [tsc_pkg::FIELD_W-1:0] x1, y1, z1,
  input  logic signed [tsc_pkg::FIELD_W-1:0] x2, y2, z2,
  output logic [2*COORD_BITS+1:0]            h1,
  output logic [2*COORD_BITS+1:0]            h2,
  output logic [2*COORD_BITS+1:0]            h3
);

  localparam int unsigned FW = tsc_pkg::FIELD_W;
  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned EW = (CW > FW) ? CW : FW;
  localparam int unsigned DW = CW + 1;        // signed difference
  localparam int unsigned MW = CW;            // magnitude of a difference
  localparam int unsigned SQ = 2 * MW;
  localparam int unsigned HW = 2 * CW + 2;

  logic signed [FW-1:0] raw      [3][3];
  logic signed [CW-1:0] crd      [3][3];
  logic signed [DW-1:0] diff_nxt [3][3];
  logic signed [DW-1:0] diff_r   [3][3];   // [u, v, w][axis]
  logic [MW-1:0]        mag_r    [3][3];
  logic [SQ-1:0]        sq       [3][3];
  logic [HW-1:0]        h_r      [3];

  assign raw[0][0] = x0;  assign raw[0][1] = y0;  assign raw[0][2] = z0;
  assign raw[1][0] = x1;  assign raw[1][1] = y1;  assign raw[1][2] = z1;
  assign raw[2][0] = x2;  assign raw[2][1] = y2;  assign raw[2][2] = z2;

  // take the low COORD_BITS of the sign-extended field
  always_comb begin
    logic signed [EW-1:0] ext;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        ext       = EW'(raw[k][i]);
        crd[k][i] = ext[CW-1:0];
      end
    end
    for (int i = 0; i < 3; i++) begin
      diff_nxt[0][i] = DW'(crd[1][i]) - DW'(crd[0][i]);
      diff_nxt[1][i] = DW'(crd[2][i]) - DW'(crd[0][i]);
      diff_nxt[2][i] = DW'(crd[2][i]) - DW'(crd[1][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 3; e++) begin
        for (int i = 0; i < 3; i++) begin
          diff_r[e][i] <= diff_nxt[e][i];
          mag_r[e][i]  <= diff_r[e][i][DW-1] ? MW'(-diff_r[e][i]) : MW'(diff_r[e][i]);
        end
      end
      for (int e = 0; e < 3; e++) begin
        h_r[e] <= HW'(sq[e][0]) + HW'(sq[e][1]) + HW'(sq[e][2]);
      end
    end
  end

  for (genvar ge = 0; ge < 3; ge++) begin : g_edge
    for (genvar gi = 0; gi < 3; gi++) begin : g_axis
      tsc_mul #(
        .A_W (MW),
        .B_W (MW)
      ) u_sq (
        .clk (clk),
        .en  (en),
        .a   (mag_r[ge][gi]),
        .b   (mag_r[ge][gi]),
        .p   (sq[ge][gi])
      );
    end
  end

  assign h1 = h_r[0];
  assign h2 = h_r[1];
  assign h3 = h_r[2];

endmodule

// ----- hdl/tsc_angle.sv -----
// shortest edge, needle test and the three obtuse angle tests
module tsc_angle #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [2*COORD_BITS+1:0] h1,
  input  logic [2*COORD_BITS+1:0] h2,
  input  logic [2*COORD_BITS+1:0] h3,
  output tsc_pkg::tsc_result_t    res
);

  localparam int unsigned LW    = tsc_pkg::LIMB_W;
  localparam int unsigned HW    = 2 * COORD_BITS + 2;
  localparam int unsigned SW    = HW + 2;
  localparam int unsigned PW    = 2 * HW;
  localparam int unsigned KPW   = PW + LW;
  localparam int unsigned NW    = HW + tsc_pkg::NEEDLE_EXTRA_W;
  localparam int unsigned LAT_W = (HW + LW - 1) / LW + 1;
  localparam int unsigned POS_D = LAT_W + 2;   // first stage to the compare stage
  localparam int unsigned NDL_D = LAT_W + 1;   // needle stage to the compare stage

  logic [HW-1:0]        hr_r [3];
  logic                 lt21_r, lt31_r, lt32_r, lt13_r, lt23_r;
  logic signed [SW-1:0] sm   [3];            // index is the vertex
  logic [HW-1:0]        m_r  [3];
  logic [2:0]           pos_r;
  logic [HW-1:0]        pa   [3];
  logic [HW-1:0]        pb   [3];

  logic [HW-1:0]        hmin_r, hmax_r;
  logic [1:0]           edge_r;
  logic                 needle_r;
  logic [1:0]           edge3_r;

  logic [PW-1:0]        msq  [3];
  logic [PW-1:0]        prd  [3];
  logic [KPW-1:0]       kp   [3];
  logic [PW-1:0]        msq_d1_r [3];
  logic [PW-1:0]        msq_d2_r [3];
  logic [2:0]           pos_dl_r [POS_D];
  logic                 ndl_dl_r [NDL_D];
  logic [1:0]           edg_dl_r [NDL_D];
  logic [2:0]           ob_r;

  // twice the dot product at a vertex is minus sm; the vertex is a candidate when sm > 0
  always_comb begin
    sm[0] = SW'(h3) - SW'(h1) - SW'(h2);
    sm[1] = SW'(h2) - SW'(h1) - SW'(h3);
    sm[2] = SW'(h1) - SW'(h2) - SW'(h3);
  end

  assign pa[0] = hr_r[0];  assign pb[0] = hr_r[1];
  assign pa[1] = hr_r[0];  assign pb[1] = hr_r[2];
  assign pa[2] = hr_r[1];  assign pb[2] = hr_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      hr_r[0] <= h1;
      hr_r[1] <= h2;
      hr_r[2] <= h3;
      lt21_r  <= h2 < h1;
      lt31_r  <= h3 < h1;
      lt32_r  <= h3 < h2;
      lt13_r  <= h1 < h3;
      lt23_r  <= h2 < h3;
      for (int a = 0; a < 3; a++) begin
        m_r[a]   <= sm[a][HW-1:0];
        pos_r[a] <= !sm[a][SW-1] && (sm[a] != '0);
      end

      // shortest edge with strict compares
      if (lt21_r) begin
        edge_r <= (lt32_r) ? tsc_pkg::EDGE_P1P2 : tsc_pkg::EDGE_P0P2;
        hmin_r <= (lt32_r) ? hr_r[2] : hr_r[1];
        hmax_r <= (!lt32_r && lt13_r) ? hr_r[2] : hr_r[0];
      end else begin
        edge_r <= (lt31_r) ? tsc_pkg::EDGE_P1P2 : tsc_pkg::EDGE_P0P1;
        hmin_r <= (lt31_r) ? hr_r[2] : hr_r[0];
        hmax_r <= (!lt31_r && lt23_r) ? hr_r[2] : hr_r[1];
      end

      needle_r <= (NW'(hmin_r) * NW'(tsc_pkg::NEEDLE_RATIO)) < NW'(hmax_r);
      edge3_r  <= edge_r;

      ndl_dl_r[0] <= needle_r;
      edg_dl_r[0] <= edge3_r;
      for (int k = 1; k < NDL_D; k++) begin
        ndl_dl_r[k] <= ndl_dl_r[k-1];
        edg_dl_r[k] <= edg_dl_r[k-1];
      end

      pos_dl_r[0] <= pos_r;
      for (int k = 1; k < POS_D; k++) pos_dl_r[k] <= pos_dl_r[k-1];

      for (int a = 0; a < 3; a++) begin
        msq_d1_r[a] <= msq[a];
        msq_d2_r[a] <= msq_d1_r[a];
        ob_r[a]     <= pos_dl_r[POS_D-1][a] &&
                       ((KPW'(msq_d2_r[a]) << tsc_pkg::COS2_SHIFT) > kp[a]);
      end
    end
  end

  for (genvar ga = 0; ga < 3; ga++) begin : g_vtx
    tsc_mul #(
      .A_W (HW),
      .B_W (HW)
    ) u_dot_sq (
      .clk (clk),
      .en  (en),
      .a   (m_r[ga]),
      .b   (m_r[ga]),
      .p   (msq[ga])
    );

    tsc_mul #(
      .A_W (HW),
      .B_W (HW)
    ) u_len_prod (
      .clk (clk),
      .en  (en),
      .a   (pa[ga]),
      .b   (pb[ga]),
      .p   (prd[ga])
    );

    tsc_mul #(
      .A_W (LW),
      .B_W (PW)
    ) u_cos_scale (
      .clk (clk),
      .en  (en),
      .a   (tsc_pkg::COS2_Q32),
      .b   (prd[ga]),
      .p   (kp[ga])
    );
  end

  // needle first, then vertex 0, then vertex 2, then vertex 1
  always_comb begin
    res.shape_class = tsc_pkg::CLASS_OK;
    res.edge_index  = edg_dl_r[NDL_D-1];
    if (ndl_dl_r[NDL_D-1]) begin
      res.shape_class = tsc_pkg::CLASS_NEEDLE;
    end else if (ob_r[0]) begin
      res.shape_class = tsc_pkg::CLASS_OBTUSE;
      res.edge_index  = tsc_pkg::EDGE_P1P2;
    end else if (ob_r[2]) begin
      res.shape_class = tsc_pkg::CLASS_OBTUSE;
      res.edge_index  = tsc_pkg::EDGE_P0P1;
    end else if (ob_r[1]) begin
      res.shape_class = tsc_pkg::CLASS_OBTUSE;
      res.edge_index  = tsc_pkg::EDGE_P0P2;
    end
  end

endmodule

// ----- hdl/triangle_shape_classifier.sv -----
// Triangle shape classifier: one triangle per clock cycle while results are taken, fully
// pipelined. A triangle taken at the input passes through the edge stages (differences,
// magnitudes, limb squaring, length sum), then the angle stages (compares, needle test,
// limb multipliers for the exact cosine test, final compare) and the output register. The
// whole pipeline advances together, so it keeps taking a triangle every cycle while results
// are taken, and it freezes in place, with in_ch.ready low, while a result waits unaccepted.
module triangle_shape_classifier #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  tsc_in_if.sink    in_ch,
  tsc_out_if.source out_ch
);

  localparam int unsigned LW    = tsc_pkg::LIMB_W;
  localparam int unsigned HW    = 2 * COORD_BITS + 2;
  localparam int unsigned LAT_S = (COORD_BITS + LW - 1) / LW + 1;
  localparam int unsigned LAT_W = (HW + LW - 1) / LW + 1;
  localparam int unsigned LE    = LAT_S + 3;
  localparam int unsigned LA    = LAT_W + 4;
  localparam int unsigned NV    = LE + LA;

  logic                 en;
  logic [NV-1:0]        vld_r;
  logic                 out_valid_r;
  tsc_pkg::tsc_result_t res;
  tsc_pkg::tsc_result_t res_r;
  logic [HW-1:0]        h1, h2, h3;

  // the pipeline moves whenever the output register is empty or being read
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NV-2:0], in_ch.valid};
      out_valid_r <= vld_r[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res;
    end
  end

  tsc_edge #(
    .COORD_BITS (COORD_BITS)
  ) u_edge (
    .clk (clk),
    .en  (en),
    .x0  (in_ch.x0),
    .y0  (in_ch.y0),
    .z0  (in_ch.z0),
    .x1  (in_ch.x1),
    .y1  (in_ch.y1),
    .z1  (in_ch.z1),
    .x2  (in_ch.x2),
    .y2  (in_ch.y2),
    .z2  (in_ch.z2),
    .h1  (h1),
    .h2  (h2),
    .h3  (h3)
  );

  tsc_angle #(
    .COORD_BITS (COORD_BITS)
  ) u_angle (
    .clk (clk),
    .en  (en),
    .h1  (h1),
    .h2  (h2),
    .h3  (h3),
    .res (res)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.shape_class = res_r.shape_class;
  assign out_ch.edge_index  = res_r.edge_index;

endmodule

// ----- hdl/tsc_chk.sv -----
// port checker for the triangle shape classifier and its bind
module tsc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] shape_class,
  input logic [1:0] edge_index
);

  // a result stays offered until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && !out_ready |=> $stable(shape_class) && $stable(edge_index))
    else $error("stalled result changed");

  // back-pressure reaches the input only from a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (shape_class == tsc_pkg::CLASS_OK || shape_class == tsc_pkg::CLASS_NEEDLE ||
                   shape_class == tsc_pkg::CLASS_OBTUSE) &&
                  (edge_index == tsc_pkg::EDGE_P1P2 || edge_index == tsc_pkg::EDGE_P0P2 ||
                   edge_index == tsc_pkg::EDGE_P0P1))
    else $error("illegal class or edge code");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind triangle_shape_classifier tsc_chk u_tsc_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .shape_class (out_ch.shape_class),
  .edge_index  (out_ch.edge_index)
);
